// File: rtl/core/saan_pkg.sv
// ----------------------------------------------------------------------------
// saan_pkg
// Shared types and constants for the sensor average autorange normalizer.
// ----------------------------------------------------------------------------
package saan_pkg;

  localparam int Channels  = 13;
  localparam int Window    = 15;
  localparam int ChW       = 4;
  localparam int MvW       = 12;
  localparam int SumW      = 16;
  localparam int HistDepth = Channels * Window;
  localparam int HistAw    = $clog2(HistDepth);
  localparam int WinW      = $clog2(Window + 1);
  localparam int DivW      = 26;

  // window sum / Window as multiply by rounded-up reciprocal, then shift
  localparam int AvgShift  = 20;
  localparam int AvgRecip  = ((2 ** AvgShift) + Window - 1) / Window;
  localparam int AvgProdW  = SumW + 17;

  localparam logic [0:0] CfgOutputMax = 1'b0;
  localparam logic [0:0] CfgFilterEn  = 1'b1;

  localparam logic KindSample = 1'b0;
  localparam logic KindReset  = 1'b1;

  typedef struct packed {
    logic           kind;
    logic [ChW-1:0] channel;
    logic [MvW-1:0] millivolts;
  } in_item_t;

  typedef struct packed {
    logic [ChW-1:0] out_channel;
    logic [MvW-1:0] filtered_mv;
    logic [MvW-1:0] level;
    logic           range_zero;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic hist_upd;
    logic calib;
    logic div_start;
    logic out_load;
    logic clear_cal;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_sts_t;

endpackage

// File: rtl/core/saan_ram.sv
// ----------------------------------------------------------------------------
// saan_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module saan_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// File: rtl/core/saan_datapath.sv
// ----------------------------------------------------------------------------
// saan_datapath
// History ring, window sums, min/max tracking and a restoring divider.
// ----------------------------------------------------------------------------
module saan_datapath (
  input  logic                clk,
  input  logic                rst,
  input  saan_pkg::in_item_t  in_item,
  input  saan_pkg::dp_cmd_t   cmd,
  input  logic [11:0]         output_max,
  input  logic                filter_enable,
  output saan_pkg::dp_sts_t   sts,
  output saan_pkg::out_item_t out_item
);
  import saan_pkg::*;

  logic [ChW-1:0]  ch;
  logic [MvW-1:0]  mv;
  logic [WinW-1:0] ptr [Channels];
  logic [SumW-1:0] wsum [Channels];
  logic [Channels-1:0] cal_valid;
  logic [Channels-1:0] filled;
  logic [MvW-1:0]  tmax [Channels];
  logic [MvW-1:0]  tmin [Channels];
  logic [HistAw-1:0] haddr;
  logic [MvW-1:0]  hrd;
  logic [SumW-1:0] nsum;
  logic [AvgProdW-1:0] qprod;
  logic [MvW-1:0]  avg, v, mn, mx, rng;
  logic            zero;
  logic [DivW-1:0] num, rem_q;
  logic [DivW-1:0] den;
  logic [4:0]      cnt;
  logic            busy;
  logic [DivW:0]   trial;
  logic [DivW-1:0] rem;
  logic [23:0]     prod;

  // slot at ptr holds data only once the channel's ring has wrapped
  assign haddr = HistAw'(ch * Window + ptr[ch]);
  assign nsum  = wsum[ch] - (filled[ch] ? SumW'(hrd) : '0) + SumW'(mv);
  assign qprod = AvgProdW'(nsum) * AvgProdW'(AvgRecip);

  saan_ram #(.Width(MvW), .Depth(HistDepth)) u_hist (
    .clk(clk), .we(cmd.hist_upd), .addr(haddr), .wdata(mv), .rdata(hrd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_valid <= '0;
      filled    <= '0;
      busy      <= 1'b0;
      for (int i = 0; i < Channels; i++) begin
        ptr[i]  <= '0;
        wsum[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        ch <= in_item.channel;
        mv <= in_item.millivolts;
      end
      if (cmd.clear_cal) begin
        cal_valid <= '0;
      end
      if (cmd.hist_upd) begin
        wsum[ch] <= nsum;
        ptr[ch]  <= (ptr[ch] == WinW'(Window - 1)) ? '0 : ptr[ch] + 1'b1;
        if (ptr[ch] == WinW'(Window - 1)) filled[ch] <= 1'b1;
        avg      <= qprod[AvgShift +: MvW];
      end
      if (cmd.calib) begin
        cal_valid[ch] <= 1'b1;
        if (!cal_valid[ch] || v > tmax[ch]) tmax[ch] <= v;
        if (!cal_valid[ch] || v < tmin[ch]) tmin[ch] <= v;
        mx <= (!cal_valid[ch] || v > tmax[ch]) ? v : tmax[ch];
        mn <= (!cal_valid[ch] || v < tmin[ch]) ? v : tmin[ch];
        prod <= 24'(v - ((!cal_valid[ch] || v < tmin[ch]) ? v : tmin[ch])) * 24'(output_max);
      end
      if (cmd.div_start) begin
        num   <= {1'b0, prod, 1'b0} + DivW'(rng);
        den   <= {13'b0, rng, 1'b0};
        rem_q <= '0;
        cnt   <= 5'(DivW);
        busy  <= 1'b1;
      end else if (busy) begin
        num   <= {num[DivW-2:0], ~trial[DivW]};
        rem_q <= trial[DivW] ? rem : trial[DivW-1:0];
        cnt   <= cnt - 5'd1;
        if (cnt == 5'd1) busy <= 1'b0;
      end
      if (cmd.out_load) begin
        out_item.out_channel <= ch;
        out_item.filtered_mv <= v;
        out_item.level       <= zero ? '0 : num[MvW-1:0];
        out_item.range_zero  <= zero;
      end
    end
  end

  assign v     = filter_enable ? avg : mv;
  assign rng   = mx - mn;
  assign zero  = (mx == mn);
  assign rem   = {rem_q[DivW-2:0], num[DivW-1]};
  assign trial = {1'b0, rem} - {1'b0, den};
  assign sts.div_done = !busy;
endmodule

// File: rtl/core/saan_ctrl.sv
// ----------------------------------------------------------------------------
// saan_ctrl
// Sequencer: accept, history read/update, calibrate, divide, deliver.
// ----------------------------------------------------------------------------
module saan_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  saan_pkg::in_item_t in_item,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  saan_pkg::dp_sts_t  sts,
  output saan_pkg::dp_cmd_t  cmd
);
  import saan_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_UPD, S_CAL, S_START, S_DIV, S_OUT
  } state_t;

  state_t state;
  logic   acc;

  assign in_stall = (state != S_IDLE);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    cmd.load      = acc;
    cmd.clear_cal = acc && in_item.kind == KindReset;
    cmd.hist_upd  = (state == S_UPD);
    cmd.calib     = (state == S_CAL);
    cmd.div_start = (state == S_START);
    cmd.out_load  = (state == S_DIV) && sts.div_done && !(out_valid && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (acc && in_item.kind == KindSample && in_item.channel < ChW'(Channels)) begin
            state <= S_READ;
          end
        end
        S_READ:  state <= S_UPD;
        S_UPD:   state <= S_CAL;
        S_CAL:   state <= S_START;
        S_START: state <= S_DIV;
        S_DIV: begin
          if (cmd.out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/core/sensor_average_autorange_normalizer.sv
// ----------------------------------------------------------------------------
// sensor_average_autorange_normalizer
// Per-channel boxcar average (bypassable) with min/max auto-ranging to 0..output_max.
// ----------------------------------------------------------------------------
// Input beats carry a sample (kind 0) or a calibration reset (kind 1).
// A sample for a valid channel yields one output beat; a reset beat or a
// sample for an out-of-range channel yields none and leaves the block idle.
// A sample's output beat goes valid after the history RAM read, window
// update, calibration, divider load, a 26-step restoring divider (one bit
// per cycle) and the load of the output register. The next input is
// accepted only once the block is back in idle, one sample at a time.
// in_stall stays high while an item is in progress; the output
// register holds a result until taken, and the next item may start
// meanwhile, but it waits at the end of its divide while that beat stalls.
// Configuration writes (index 0 output_max, 1 filter_enable) are always
// ready and must be issued while the block is idle.
// After rst, window sums, history pointers and fill flags are zero; a
// history slot counts as zero until its channel's ring has wrapped once.
// ----------------------------------------------------------------------------
module sensor_average_autorange_normalizer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  saan_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output saan_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [11:0]         cfg_data
);
  import saan_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [11:0] output_max;
  logic        filter_enable;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_max    <= 12'd255;
      filter_enable <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgOutputMax: output_max    <= cfg_data;
        CfgFilterEn:  filter_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  saan_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_item(in_data),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .sts(sts), .cmd(cmd)
  );

  saan_datapath u_dp (
    .clk(clk), .rst(rst), .in_item(in_data), .cmd(cmd),
    .output_max(output_max), .filter_enable(filter_enable),
    .sts(sts), .out_item(out_data)
  );
endmodule
